// File: hw/rtl/bmpp_pkg.sv
// Shared types, constants and the MIDI status length table for the packet parser.
package bmpp_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int ADDR_W       = 6;
  localparam int CNT_W        = 7;
  localparam int HIGH_BIT     = 7;
  localparam logic [CNT_W-1:0] MIN_PACKET = 7'd3;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] len;
  } msg_t;

  typedef struct packed {
    logic push;
    logic flush;
  } ctl_t;

  // Zero means the status ends parsing.
  function automatic logic [1:0] status_length(input logic [7:0] s);
    logic [1:0] ml;
    ml = 2'd0;
    if (!s[HIGH_BIT]) begin
      ml = 2'd0;
    end else if (s < 8'hC0) begin
      ml = 2'd3;
    end else if (s < 8'hE0) begin
      ml = 2'd2;
    end else if (s < 8'hF0) begin
      ml = 2'd3;
    end else begin
      case (s)
        8'hF1: ml = 2'd2;
        8'hF2: ml = 2'd3;
        8'hF3: ml = 2'd2;
        8'hF6: ml = 2'd1;
        default: ml = (s >= 8'hF8) ? 2'd1 : 2'd0;
      endcase
    end
    return ml;
  endfunction

endpackage

// File: hw/rtl/bmpp_out_stage.sv
// Output stage: holds one message back so the last one of a packet can be tagged.
module bmpp_out_stage (
  input  logic            clk,
  input  logic            rst,
  input  bmpp_pkg::ctl_t  ctl,
  input  bmpp_pkg::msg_t  msg,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      status_byte,
  output logic [7:0]      first_data,
  output logic [7:0]      second_data,
  output logic [1:0]      message_length,
  output logic            last_message
);
  import bmpp_pkg::*;

  msg_t pend;
  logic pend_valid;
  logic out_free;
  logic load_out;

  assign out_free = !out_valid || !out_stall;
  assign ready    = !pend_valid || out_free;
  assign load_out = ready && (ctl.push || ctl.flush) && pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid      <= 1'b1;
        status_byte    <= pend.status;
        first_data     <= pend.d1;
        second_data    <= pend.d2;
        message_length <= pend.len;
        // a newer message exists on push, so the held one is not the last
        last_message   <= !ctl.push;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctl.push && ready) begin
        pend       <= msg;
        pend_valid <= 1'b1;
      end else if (ctl.flush && ready) begin
        pend_valid <= 1'b0;
      end
    end
  end

  a_flush_empties: assert property (@(posedge clk) disable iff (rst)
    (ctl.flush && !ctl.push && ready) |=> !pend_valid)
    else $error("held message survived a flush");

  a_push_holds: assert property (@(posedge clk) disable iff (rst)
    (ctl.push && ready) |=> pend_valid)
    else $error("pushed message not held");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid &&
      $stable({status_byte, first_data, second_data, message_length, last_message})))
    else $error("stalled output word changed");

endmodule

// File: hw/rtl/ble_midi_packet_parser_core.sv
// BLE MIDI packet parser: byte loader, packet store and message extraction.
//
// Input channel (in_valid / in_stall): one packet byte per word, packet_end
// set on the final byte. While loading, a byte is taken every cycle. Bytes
// past the 64th of a packet are dropped; packet_end on them still closes it.
// When the final byte is taken the block stalls its input and parses the
// stored packet out of a one-port synchronous store (one read per cycle,
// registered read data). A skipped byte passes S_SCAN, S_HEAD; a message
// S_SCAN, S_HEAD, S_PAIR (which takes in a timestamp; skipped on the last
// byte), S_STAT, a data state per data byte, S_PUSH; S_FLUSH ends the scan.
// Short packets and packets with a bad header take no parse time.
// Output channel (out_valid / out_stall): one MIDI message per word. A message
// leaves once the next one of the packet is found or parsing ends, the last
// one with last_message set. A stall on the output holds the parser once its
// held message and the output register are both full.
// Reset clears the byte count and empties the output; the store is not cleared.
module ble_midi_packet_parser_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] packet_byte,
  input  logic       packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] status_byte,
  output logic [7:0] first_data,
  output logic [7:0] second_data,
  output logic [1:0] message_length,
  output logic       last_message
);
  import bmpp_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_SCAN, S_HEAD, S_PAIR, S_STAT, S_DATA1, S_DATA2, S_PUSH, S_FLUSH
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             hdr_ok;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] pos;
  msg_t             cur;
  logic [7:0]       mem [PACKET_BYTES];
  logic [7:0]       rd_data;
  logic [ADDR_W-1:0] rd_addr;

  logic             in_acc;
  logic             room;
  logic [CNT_W-1:0] len_end;
  logic             hdr_end;
  logic [1:0]       ml_cur;
  logic             ready;
  ctl_t             ctl;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && (state == S_LOAD);
  assign room     = count < CNT_W'(PACKET_BYTES);
  assign len_end  = room ? count + 7'd1 : count;
  assign hdr_end  = (count == '0) ? packet_byte[HIGH_BIT] : hdr_ok;
  assign ml_cur   = status_length(cur.status);
  assign ctl.push  = (state == S_PUSH);
  assign ctl.flush = (state == S_FLUSH);

  always_comb begin
    case (state)
      S_HEAD:  rd_addr = ADDR_W'(idx + 7'd1);
      S_STAT:  rd_addr = ADDR_W'(pos + 7'd1);
      S_DATA1: rd_addr = ADDR_W'(pos + 7'd2);
      default: rd_addr = idx[ADDR_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc && room) begin
      mem[count[ADDR_W-1:0]] <= packet_byte;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      count  <= '0;
      hdr_ok <= 1'b0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (room && count == '0) hdr_ok <= packet_byte[HIGH_BIT];
            if (packet_end) begin
              count <= '0;
              len   <= len_end;
              idx   <= 7'd1;
              if (len_end >= MIN_PACKET && hdr_end) state <= S_SCAN;
            end else if (room) begin
              count <= count + 7'd1;
            end
          end
        end
        S_SCAN: begin
          state <= (idx >= len) ? S_FLUSH : S_HEAD;
        end
        S_HEAD: begin
          if (!rd_data[HIGH_BIT]) begin
            // skip data byte outside a message
            idx   <= idx + 7'd1;
            state <= S_SCAN;
          end else begin
            cur.status <= rd_data;
            pos        <= idx;
            state      <= (idx + 7'd1 < len) ? S_PAIR : S_STAT;
          end
        end
        S_PAIR: begin
          // two high bytes in a row: the first is a timestamp
          if (rd_data[HIGH_BIT]) begin
            cur.status <= rd_data;
            pos        <= idx + 7'd1;
          end
          state <= S_STAT;
        end
        S_STAT: begin
          cur.len <= ml_cur;
          cur.d1  <= '0;
          cur.d2  <= '0;
          if (ml_cur == 2'd0 || pos + CNT_W'(ml_cur) > len) begin
            state <= S_FLUSH;
          end else if (ml_cur == 2'd1) begin
            state <= S_PUSH;
          end else begin
            state <= S_DATA1;
          end
        end
        S_DATA1: begin
          cur.d1 <= rd_data;
          state  <= (cur.len == 2'd3) ? S_DATA2 : S_PUSH;
        end
        S_DATA2: begin
          cur.d2 <= rd_data;
          state  <= S_PUSH;
        end
        S_PUSH: begin
          if (ready) begin
            idx   <= pos + CNT_W'(cur.len);
            state <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (ready) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  bmpp_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .msg            (cur),
    .ready          (ready),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status_byte    (status_byte),
    .first_data     (first_data),
    .second_data    (second_data),
    .message_length (message_length),
    .last_message   (last_message)
  );

  a_idx_in_packet: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (idx <= len))
    else $error("scan index ran past packet length");

  a_parse_len: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (len >= MIN_PACKET && len <= CNT_W'(PACKET_BYTES)))
    else $error("parsing a packet of illegal length");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH) |-> (cur.len != 2'd0 && pos + CNT_W'(cur.len) <= len))
    else $error("pushed message overruns packet");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_LOAD) |-> (count == '0))
    else $error("byte count not cleared at packet end");

endmodule

// File: tb/ble_midi_packet_parser_core_test.sv
// Self-checking testbench for the BLE MIDI packet parser core.
module ble_midi_packet_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] status;
    logic [7:0] d1;
    logic [7:0] d2;
    logic [1:0] len;
    logic       last;
  } midi_msg_t;

  // Mirrors the packet store and extracts the messages each closed packet yields.
  class midi_scoreboard;
    logic [7:0]  pkt_bytes [64];
    int unsigned fill;
    midi_msg_t   expected_q [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
    endfunction

    // Bytes in a message that starts with status s; zero ends the scan.
    function int unsigned msg_bytes(logic [7:0] s);
      int unsigned n;
      n = 0;
      case (s[7:4])
        4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 3;
        4'hC, 4'hD: n = 2;
        4'hF: begin
          if (s[3]) n = 1;
          else if (s[2:0] == 3'd1 || s[2:0] == 3'd3) n = 2;
          else if (s[2:0] == 3'd2) n = 3;
          else if (s[2:0] == 3'd6) n = 1;
        end
        default: n = 0;
      endcase
      return n;
    endfunction

    function void note_word(logic [7:0] b, logic e);
      midi_msg_t   found [$];
      midi_msg_t   m;
      int unsigned n;
      int unsigned i;
      int unsigned ml;
      if (fill < 64) begin
        pkt_bytes[fill] = b;
        fill++;
      end
      if (!e) return;
      n = fill;
      fill = 0;
      if (n < 3 || !pkt_bytes[0][7]) return;
      i = 1;
      while (i < n && found.size() < 63) begin
        // two high bytes in a row: the first is a timestamp
        if (i + 1 < n && pkt_bytes[i][7] && pkt_bytes[i+1][7]) i++;
        if (i >= n) break;
        if (!pkt_bytes[i][7]) begin
          i++;
          continue;
        end
        ml = msg_bytes(pkt_bytes[i]);
        if (ml == 0 || i + ml > n) break;
        m.status = pkt_bytes[i];
        m.d1     = (ml > 1) ? pkt_bytes[i+1] : 8'h00;
        m.d2     = (ml > 2) ? pkt_bytes[i+2] : 8'h00;
        m.len    = ml[1:0];
        m.last   = 1'b0;
        found.push_back(m);
        i += ml;
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) expected_q.push_back(found[k]);
    endfunction

    function void check_msg(logic [7:0] status, logic [7:0] d1, logic [7:0] d2,
                            logic [1:0] len, logic last);
      midi_msg_t want;
      checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected message: status_byte %02h", status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        $error("status_byte: expected %02h, got %02h", want.status, status);
        errors++;
      end
      if (d1 !== want.d1) begin
        $error("first_data: expected %02h, got %02h", want.d1, d1);
        errors++;
      end
      if (d2 !== want.d2) begin
        $error("second_data: expected %02h, got %02h", want.d2, d2);
        errors++;
      end
      if (len !== want.len) begin
        $error("message_length: expected %0d, got %0d", want.len, len);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_message: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] packet_byte;
  logic       packet_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] status_byte;
  logic [7:0] first_data;
  logic [7:0] second_data;
  logic [1:0] message_length;
  logic       last_message;

  midi_scoreboard sb;
  int unsigned    n_items;
  int unsigned    n_packets;
  int unsigned    n_long;

  ble_midi_packet_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .packet_byte    (packet_byte),
    .packet_end     (packet_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status_byte    (status_byte),
    .first_data     (first_data),
    .second_data    (second_data),
    .message_length (message_length),
    .last_message   (last_message)
  );

  initial clk = 1'b0;
  always #4ns clk = ~clk;

  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: check each accepted word, then stall a random while.
  initial begin
    int unsigned hold;
    int unsigned since_mode;
    bit          calm;
    hold = 0;
    since_mode = 0;
    calm = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_msg(status_byte, first_data, second_data, message_length, last_message);
        since_mode++;
        if (since_mode >= 16) begin
          since_mode = 0;
          calm = ($urandom_range(0, 3) == 0);
        end
        hold = calm ? 0 : $urandom_range(0, 7);
      end
      @(negedge clk);
      out_stall = (hold > 0);
      if (hold > 0) hold--;
    end
  end

  task automatic send_word(input logic [7:0] b, input logic e, input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    packet_byte = b;
    packet_end = e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(b, e);
  endtask

  task automatic send_packet(input logic [7:0] pkt [$]);
    bit no_gaps;
    no_gaps = ($urandom_range(0, 3) == 0);
    foreach (pkt[k]) begin
      send_word(pkt[k], (k == pkt.size() - 1), no_gaps);
      if (k < 64) n_items++;
    end
    n_packets++;
  endtask

  // Append an optional timestamp, a status and its data bytes.
  function automatic void add_message(ref logic [7:0] pkt [$]);
    logic [7:0]  s;
    int unsigned ml;
    if ($urandom_range(0, 9) < 7) pkt.push_back({1'b1, 7'($urandom)});
    if ($urandom_range(0, 9) < 7) s = 8'($urandom_range(8'h80, 8'hEF));
    else s = 8'($urandom_range(8'hF0, 8'hFF));
    pkt.push_back(s);
    ml = sb.msg_bytes(s);
    for (int j = 1; j < ml; j++) begin
      if ($urandom_range(0, 19) == 0) pkt.push_back(8'($urandom));
      else pkt.push_back({1'b0, 7'($urandom)});
    end
    // stray running-status data byte
    if ($urandom_range(0, 9) == 0) pkt.push_back({1'b0, 7'($urandom)});
  endfunction

  task automatic directed_packets();
    logic [7:0] pkt [$];
    pkt = '{8'hFF};
    send_packet(pkt);
    pkt = '{8'h7F, 8'h90, 8'h40};
    send_packet(pkt);
    // timestamp, note on, then a poly aftertouch that overruns the packet
    pkt = '{8'h80, 8'h80, 8'h90, 8'h3C, 8'h7F, 8'hA0, 8'h10};
    send_packet(pkt);
    pkt = '{8'hBF, 8'hC0, 8'h05, 8'h12, 8'hF8, 8'hF6, 8'hF1, 8'h22, 8'hF2, 8'h10, 8'h20};
    send_packet(pkt);
    // pitch bend, then a zero-length status ends the scan
    pkt = '{8'h81, 8'hE0, 8'h00, 8'h7F, 8'hF7, 8'h55};
    send_packet(pkt);
  endtask

  task automatic random_packets();
    logic [7:0]  pkt [$];
    int unsigned kind;
    int unsigned cut;
    int unsigned target;
    while (n_items < 420) begin
      kind = $urandom_range(0, 99);
      pkt.delete();
      if (kind < 70) begin
        pkt.push_back({1'b1, 7'($urandom)});
        repeat ($urandom_range(1, 6)) add_message(pkt);
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 12)) pkt.push_back(8'($urandom));
      end else if (kind < 88) begin
        pkt.push_back({1'b1, 7'($urandom)});
        repeat ($urandom_range(1, 4)) add_message(pkt);
        cut = $urandom_range(1, pkt.size());
        while (pkt.size() > cut) void'(pkt.pop_back());
        if ($urandom_range(0, 1) == 1) pkt[0][7] = 1'b0;
      end else if (kind < 94 && n_long < 4) begin
        // run up to or past the store so any bytes past the 64th are dropped
        target = $urandom_range(60, 72);
        pkt.push_back({1'b1, 7'($urandom)});
        while (pkt.size() < target) add_message(pkt);
        n_long++;
      end else begin
        repeat ($urandom_range(1, 2)) pkt.push_back(8'($urandom));
      end
      send_packet(pkt);
    end
  endtask

  initial begin
    sb = new();
    n_items = 0;
    n_packets = 0;
    n_long = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    packet_byte = 8'h00;
    packet_end = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_packets();
    random_packets();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    // let a packet with no messages finish its scan
    repeat (400) @(posedge clk);
    $display("Sent %0d packets (%0d stored bytes, %0d long packets near the store limit).",
             n_packets, n_items, n_long);
    $display("Compared %0d extracted messages against the prediction.", sb.checked);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bmpp_pkg.sv
hw/rtl/bmpp_out_stage.sv
hw/rtl/ble_midi_packet_parser_core.sv
tb/ble_midi_packet_parser_core_test.sv
